// ----- rtl/core/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivision package
// Shared constants and types of the triangle subdivision block.
// ----------------------------------------------------------------------------
package sts_pkg;

   // Default coordinate format: signed Q2.14.
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Magnitudes are normalized so that the largest lies in [2^30, 2^31).
   localparam int UN_W        = 31;
   localparam int SQ_W        = 2 * UN_W;
   localparam int ACC_W       = 64;
   localparam int ROOT_W      = 32;
   localparam int ROOT_STEPS  = ACC_W / 2;
   localparam int ROOT_REM_W  = ROOT_W + 2;
   localparam int DIV_REM_W   = ROOT_W + 3;
   localparam int CNT_W       = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Back end sequencer, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOAD  = 9'b000000010,
      ST_NORM  = 9'b000000100,
      ST_SQ    = 9'b000001000,
      ST_ROOT  = 9'b000010000,
      ST_DIVI  = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_STORE = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } back_state_type;

   // Handshake between the queue head and the back end.
   typedef struct packed {
      logic valid;
   } head_status_type;

   typedef struct packed {
      logic pop;
   } head_ctrl_type;

endpackage

// ----- rtl/core/sts_if.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivision channels
// Valid/ready channels for input triangles and output triangles.
// ----------------------------------------------------------------------------
interface sts_req_if #(
   parameter int COORD_BITS = sts_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
   logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
   logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

   modport source (
      output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
      input  ready
   );
   modport sink (
      input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
      output ready
   );
endinterface

interface sts_rsp_if #(
   parameter int COORD_BITS = sts_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z;
   logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z;
   logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z;
   logic                         last_of_run;

   modport source (
      output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
             last_of_run,
      input  ready
   );
   modport sink (
      input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
             last_of_run,
      output ready
   );
endinterface

// ----- rtl/core/sts_front.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivision front end
// Accepts triangles, forms the edge sum of each pair of vertices and queues them.
// ----------------------------------------------------------------------------
module sts_front #(
   parameter int COORD_BITS = sts_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   sts_req_if.sink                       req_ch,
   output sts_pkg::head_status_type      hd_status,
   input  sts_pkg::head_ctrl_type        hd_ctrl,
   output logic [COORD_BITS-1:0]         hd_verts [3][3],
   output logic [COORD_BITS:0]           hd_sums  [3][3]
);
   localparam int C  = COORD_BITS;
   localparam int SW = C + 1;
   localparam int CW = sts_pkg::QPTR_W + 1;

   logic [C-1:0]              in_v [3][3];
   logic [SW-1:0]             in_s [3][3];
   logic [C-1:0]              q_v_ff [sts_pkg::QUEUE_DEPTH][3][3];
   logic [SW-1:0]             q_s_ff [sts_pkg::QUEUE_DEPTH][3][3];
   logic [sts_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      push, pop;

   assign in_v[0][0] = req_ch.v0_x;
   assign in_v[0][1] = req_ch.v0_y;
   assign in_v[0][2] = req_ch.v0_z;
   assign in_v[1][0] = req_ch.v1_x;
   assign in_v[1][1] = req_ch.v1_y;
   assign in_v[1][2] = req_ch.v1_z;
   assign in_v[2][0] = req_ch.v2_x;
   assign in_v[2][1] = req_ch.v2_y;
   assign in_v[2][2] = req_ch.v2_z;

   // Edge sums in the order m01, m02, m12, exact at one extra bit.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_s[0][k] = {in_v[0][k][C-1], in_v[0][k]} + {in_v[1][k][C-1], in_v[1][k]};
         in_s[1][k] = {in_v[0][k][C-1], in_v[0][k]} + {in_v[2][k][C-1], in_v[2][k]};
         in_s[2][k] = {in_v[1][k][C-1], in_v[1][k]} + {in_v[2][k][C-1], in_v[2][k]};
      end
   end

   assign req_ch.ready    = (cnt_ff != CW'(sts_pkg::QUEUE_DEPTH));
   assign push            = req_ch.valid && req_ch.ready;
   assign hd_status.valid = (cnt_ff != '0);
   assign pop             = hd_ctrl.pop && hd_status.valid;
   assign hd_verts        = q_v_ff[rd_ptr_ff];
   assign hd_sums         = q_s_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_v_ff[wr_ptr_ff] <= in_v;
         q_s_ff[wr_ptr_ff] <= in_s;
      end
   end

endmodule

// ----- rtl/core/sts_back.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivision back end
// Normalizes the three midpoints with a shared datapath and sends out
// the four triangles of each input.
// ----------------------------------------------------------------------------
module sts_back #(
   parameter int COORD_BITS = sts_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sts_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sts_pkg::head_status_type      hd_status,
   output sts_pkg::head_ctrl_type        hd_ctrl,
   input  logic [COORD_BITS-1:0]         hd_verts [3][3],
   input  logic [COORD_BITS:0]           hd_sums  [3][3],
   sts_rsp_if.source                     rsp_ch
);
   localparam int C     = COORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int SW    = C + 1;
   localparam int NW    = (SW > 32) ? SW : 32;
   localparam int UN    = sts_pkg::UN_W;
   localparam int QW    = F + 1;
   localparam int NUM_W = UN + F + 2;
   localparam int RW    = sts_pkg::ROOT_W;
   localparam int RRW   = sts_pkg::ROOT_REM_W;
   localparam int DRW   = sts_pkg::DIV_REM_W;
   localparam int AW    = sts_pkg::ACC_W;
   localparam int EW    = (QW > C) ? QW : C;
   localparam int CNT_W = sts_pkg::CNT_W;

   sts_pkg::back_state_type state_ff, state_in;
   logic [1:0]        mi_ff, mi_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ev_ff, ev_in;
   logic [1:0]        ec_ff, ec_in;

   logic [C-1:0]      w_v_ff [3][3];
   logic [SW-1:0]     w_s_ff [3][3];
   logic [2:0]        neg_ff, neg_in;
   logic [NW-1:0]     u_ff [3], u_in [3];
   logic [sts_pkg::SQ_W-1:0] prod_ff, prod_in;
   logic [AW-1:0]     acc_ff, acc_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [RRW-1:0]    rrem_ff, rrem_in;
   logic [DRW-1:0]    dr_ff [3], dr_in [3];
   logic [QW-1:0]     dn_ff [3], dn_in [3];
   logic [C-1:0]      mid_ff [3][3], mid_in [3][3];
   logic [C-1:0]      e_v_ff [3][3], e_m_ff [3][3];
   logic [C-1:0]      corner [3][3];

   logic              load_w, load_e, rsp_xfer, last_xfer, all_zero, lo, hi;
   logic [SW-1:0]     s_sel, s_abs;
   logic [RRW+1:0]    r_a, r_b, r_t;
   logic [NUM_W-1:0]  num;
   logic [DRW-1:0]    d_t, den;
   logic [EW-1:0]     mag, lim;

   assign rsp_xfer  = rsp_ch.valid && rsp_ch.ready;
   assign last_xfer = rsp_xfer && (ec_ff == 2'd3);
   assign den       = DRW'({root_ff, 1'b0});
   assign lim       = EW'({(C-1){1'b1}});

   always_comb begin
      state_in = state_ff;
      mi_in    = mi_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      u_in     = u_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      root_in  = root_ff;
      rrem_in  = rrem_ff;
      dr_in    = dr_ff;
      dn_in    = dn_ff;
      mid_in   = mid_ff;
      load_w   = 1'b0;
      load_e   = 1'b0;
      all_zero = 1'b1;
      lo       = 1'b1;
      hi       = 1'b0;
      s_sel    = '0;
      s_abs    = '0;
      r_a      = '0;
      r_b      = '0;
      r_t      = '0;
      num      = '0;
      d_t      = '0;
      mag      = '0;

      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (hd_status.valid) begin
               load_w   = 1'b1;
               mi_in    = 2'd0;
               state_in = sts_pkg::ST_LOAD;
            end
         end
         sts_pkg::ST_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               s_sel     = w_s_ff[mi_ff][k];
               s_abs     = s_sel[SW-1] ? (~s_sel + 1'b1) : s_sel;
               neg_in[k] = s_sel[SW-1];
               u_in[k]   = NW'(s_abs);
               if (s_sel != '0) all_zero = 1'b0;
            end
            if (all_zero) begin
               // A midpoint at the origin comes out as zero.
               for (int k = 0; k < 3; k++) mid_in[mi_ff][k] = '0;
               mi_in    = mi_ff + 1'b1;
               state_in = (mi_ff == 2'd2) ? sts_pkg::ST_EMIT : sts_pkg::ST_LOAD;
            end else begin
               state_in = sts_pkg::ST_NORM;
            end
         end
         sts_pkg::ST_NORM: begin
            // One bit a cycle until the largest magnitude has its top bit at 30.
            for (int k = 0; k < 3; k++) begin
               if (u_ff[k][NW-1:30] != '0) lo = 1'b0;
               if (u_ff[k][NW-1:31] != '0) hi = 1'b1;
            end
            if (lo) begin
               for (int k = 0; k < 3; k++) u_in[k] = u_ff[k] << 1;
            end else if (hi) begin
               for (int k = 0; k < 3; k++) u_in[k] = u_ff[k] >> 1;
            end else begin
               cnt_in   = '0;
               state_in = sts_pkg::ST_SQ;
            end
         end
         sts_pkg::ST_SQ: begin
            if (cnt_ff[1:0] != 2'd3) prod_in = u_ff[cnt_ff[1:0]][UN-1:0] *
                                              u_ff[cnt_ff[1:0]][UN-1:0];
            acc_in = (cnt_ff == '0) ? '0 : acc_ff + AW'(prod_ff);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               root_in  = '0;
               rrem_in  = '0;
               state_in = sts_pkg::ST_ROOT;
            end
         end
         sts_pkg::ST_ROOT: begin
            // Integer square root, one result bit a cycle.
            r_a    = {rrem_ff, acc_ff[AW-1:AW-2]};
            r_b    = (RRW+2)'({root_ff, 2'b01});
            r_t    = r_a - r_b;
            acc_in = acc_ff << 2;
            if (r_a >= r_b) begin
               rrem_in = r_t[RRW-1:0];
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rrem_in = r_a[RRW-1:0];
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(sts_pkg::ROOT_STEPS - 1)) begin
               state_in = sts_pkg::ST_DIVI;
            end
         end
         sts_pkg::ST_DIVI: begin
            // Adding the root before halving the quotient rounds to nearest.
            for (int k = 0; k < 3; k++) begin
               num      = (NUM_W'(u_ff[k][UN-1:0]) << QW) + NUM_W'(root_ff);
               dr_in[k] = DRW'(num[NUM_W-1:QW]);
               dn_in[k] = num[QW-1:0];
            end
            cnt_in   = '0;
            state_in = sts_pkg::ST_DIV;
         end
         sts_pkg::ST_DIV: begin
            for (int k = 0; k < 3; k++) begin
               d_t = {dr_ff[k][DRW-2:0], dn_ff[k][QW-1]};
               if (d_t >= den) begin
                  dr_in[k] = d_t - den;
                  dn_in[k] = {dn_ff[k][QW-2:0], 1'b1};
               end else begin
                  dr_in[k] = d_t;
                  dn_in[k] = {dn_ff[k][QW-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) state_in = sts_pkg::ST_STORE;
         end
         sts_pkg::ST_STORE: begin
            for (int k = 0; k < 3; k++) begin
               mag = EW'(dn_ff[k]);
               if (mag > lim) mag = lim;
               if (neg_ff[k]) mag = ~mag + 1'b1;
               mid_in[mi_ff][k] = mag[C-1:0];
            end
            mi_in    = mi_ff + 1'b1;
            state_in = (mi_ff == 2'd2) ? sts_pkg::ST_EMIT : sts_pkg::ST_LOAD;
         end
         sts_pkg::ST_EMIT: begin
            if (!ev_ff || last_xfer) begin
               load_e   = 1'b1;
               state_in = sts_pkg::ST_IDLE;
            end
         end
         default: state_in = sts_pkg::ST_IDLE;
      endcase
   end

   assign hd_ctrl.pop = load_w;

   always_comb begin
      ev_in = ev_ff;
      ec_in = ec_ff;
      if (rsp_xfer) begin
         ec_in = ec_ff + 1'b1;
         if (ec_ff == 2'd3) ev_in = 1'b0;
      end
      if (load_e) begin
         ev_in = 1'b1;
         ec_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sts_pkg::ST_IDLE;
         mi_ff    <= '0;
         cnt_ff   <= '0;
         ev_ff    <= 1'b0;
         ec_ff    <= '0;
      end else begin
         state_ff <= state_in;
         mi_ff    <= mi_in;
         cnt_ff   <= cnt_in;
         ev_ff    <= ev_in;
         ec_ff    <= ec_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      u_ff    <= u_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      dr_ff   <= dr_in;
      dn_ff   <= dn_in;
      mid_ff  <= mid_in;
      if (load_w) begin
         w_v_ff <= hd_verts;
         w_s_ff <= hd_sums;
      end
      if (load_e) begin
         e_v_ff <= w_v_ff;
         e_m_ff <= mid_ff;
      end
   end

   // Triangle order: (m01,m02,m12), (v0,m01,m02), (v1,m01,m12), (v2,m02,m12).
   always_comb begin
      case (ec_ff)
         2'd0: corner = '{e_m_ff[0], e_m_ff[1], e_m_ff[2]};
         2'd1: corner = '{e_v_ff[0], e_m_ff[0], e_m_ff[1]};
         2'd2: corner = '{e_v_ff[1], e_m_ff[0], e_m_ff[2]};
         default: corner = '{e_v_ff[2], e_m_ff[1], e_m_ff[2]};
      endcase
   end

   assign rsp_ch.valid       = ev_ff;
   assign rsp_ch.p0_x        = corner[0][0];
   assign rsp_ch.p0_y        = corner[0][1];
   assign rsp_ch.p0_z        = corner[0][2];
   assign rsp_ch.p1_x        = corner[1][0];
   assign rsp_ch.p1_y        = corner[1][1];
   assign rsp_ch.p1_z        = corner[1][2];
   assign rsp_ch.p2_x        = corner[2][0];
   assign rsp_ch.p2_y        = corner[2][1];
   assign rsp_ch.p2_z        = corner[2][2];
   assign rsp_ch.last_of_run = (ec_ff == 2'd3);

endmodule

// ----- rtl/core/sphere_triangle_subdivide.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivision
// One step of icosphere refinement on signed fixed-point triangles.
// ----------------------------------------------------------------------------
// Each accepted triangle yields four triangles on the result channel, the
// fourth flagged with last_of_run. A two-entry queue after the input lets
// triangles be taken while earlier ones are still being worked on, and the
// result stage holds a finished triangle set while the next one is computed.
// Throughput is set by the shared midpoint datapath, which handles the three
// midpoints one after another: each is loaded, normalized by one-bit shifts
// (at most 30 of them), squared and summed, passed through the bit-serial
// square root, set up for and run through the bit-serial division, and
// stored, while a midpoint at the origin is settled at its load. Once the
// triangle has been taken from the queue and its three midpoints are done,
// the set is handed to the result stage. The hand-over waits while the
// previous four triangles are still being sent.
module sphere_triangle_subdivide #(
   parameter int COORD_BITS = sts_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sts_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_ch,
   sts_rsp_if.source rsp_ch
);
   sts_pkg::head_status_type hd_status;
   sts_pkg::head_ctrl_type   hd_ctrl;
   logic [COORD_BITS-1:0]    hd_verts [3][3];
   logic [COORD_BITS:0]      hd_sums  [3][3];

   sts_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .hd_status (hd_status),
      .hd_ctrl   (hd_ctrl),
      .hd_verts  (hd_verts),
      .hd_sums   (hd_sums)
   );

   sts_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .hd_status (hd_status),
      .hd_ctrl   (hd_ctrl),
      .hd_verts  (hd_verts),
      .hd_sums   (hd_sums),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- tb/sts_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle subdivision testbench channel helpers
// Plain record types shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package sts_tb_pkg;

   typedef logic signed [15:0] coord_type;

   typedef struct {
      coord_type x, y, z;
   } vec_type;

   typedef struct {
      vec_type p0, p1, p2;
      logic last_of_run;
   } tri_type;

endpackage

// ----- tb/sphere_triangle_subdivide_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivision testbench
// Drives triangles with random bursts and gaps, stalls the result side on a
// pattern of its own, and checks every output triangle against a predictor.
// ----------------------------------------------------------------------------

class subdivide_scoreboard;
   sts_tb_pkg::tri_type pending_tris[$];
   int   errors = 0;

   // Direction of a + b scaled to unit length, rounded and saturated.
   function sts_tb_pkg::vec_type unit_midpoint(sts_tb_pkg::vec_type a,
                                               sts_tb_pkg::vec_type b);
      longint signed s[3];
      longint unsigned u[3];
      longint unsigned m, q, len, rem, bitv, mag;
      sts_tb_pkg::vec_type r;
      s[0] = longint'(a.x) + longint'(b.x);
      s[1] = longint'(a.y) + longint'(b.y);
      s[2] = longint'(a.z) + longint'(b.z);
      m = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = (s[i] < 0) ? -s[i] : s[i];
         if (u[i] > m) m = u[i];
      end
      r.x = 0; r.y = 0; r.z = 0;
      if (m == 0) return r;
      while (m < (64'd1 << 30)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) u[i] = u[i] << 1;
      end
      while (m >= (64'd1 << 31)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) u[i] = u[i] >> 1;
      end
      q = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      // Digit-by-digit integer square root.
      len = 0;
      rem = q;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= len + bitv) begin
            rem = rem - (len + bitv);
            len = (len >> 1) + bitv;
         end else begin
            len = len >> 1;
         end
         bitv = bitv >> 2;
      end
      for (int i = 0; i < 3; i++) begin
         mag = ((u[i] << 15) + len) / (2 * len);
         if (mag > 64'd32767) mag = 64'd32767;
         s[i] = (s[i] < 0) ? -longint'(mag) : longint'(mag);
      end
      r.x = s[0][15:0]; r.y = s[1][15:0]; r.z = s[2][15:0];
      return r;
   endfunction

   function void queue_tri(sts_tb_pkg::tri_type t);
      pending_tris = {pending_tris, t};
   endfunction

   function void note_triangle(sts_tb_pkg::vec_type v0, sts_tb_pkg::vec_type v1,
                               sts_tb_pkg::vec_type v2);
      sts_tb_pkg::vec_type m01, m02, m12;
      m01 = unit_midpoint(v0, v1);
      m02 = unit_midpoint(v0, v2);
      m12 = unit_midpoint(v1, v2);
      queue_tri('{m01, m02, m12, 1'b0});
      queue_tri('{v0, m01, m02, 1'b0});
      queue_tri('{v1, m01, m12, 1'b0});
      queue_tri('{v2, m02, m12, 1'b1});
   endfunction

   function void cmp(string name, int e, int a);
      if (e != a) begin
         $error("%s mismatch: expected %0d, got %0d", name, e, a);
         errors++;
      end
   endfunction

   function void check_triangle(sts_tb_pkg::tri_type got);
      sts_tb_pkg::tri_type e;
      if (pending_tris.size() == 0) begin
         $error("output triangle with none expected");
         errors++;
         return;
      end
      e = pending_tris.pop_front();
      cmp("p0_x", e.p0.x, got.p0.x); cmp("p0_y", e.p0.y, got.p0.y);
      cmp("p0_z", e.p0.z, got.p0.z); cmp("p1_x", e.p1.x, got.p1.x);
      cmp("p1_y", e.p1.y, got.p1.y); cmp("p1_z", e.p1.z, got.p1.z);
      cmp("p2_x", e.p2.x, got.p2.x); cmp("p2_y", e.p2.y, got.p2.y);
      cmp("p2_z", e.p2.z, got.p2.z);
      cmp("last_of_run", e.last_of_run, got.last_of_run);
   endfunction
endclass

module sphere_triangle_subdivide_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   sending_done = 0;
   int   burst_left = 0;
   int   stall_phase = 0;
   subdivide_scoreboard board = new();

   sts_req_if req_ch ();
   sts_rsp_if rsp_ch ();

   sphere_triangle_subdivide uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic sts_tb_pkg::coord_type rand_coord(int mode);
      case (mode)
         0: return sts_tb_pkg::coord_type'($urandom);
         1: return sts_tb_pkg::coord_type'($urandom_range(0, 32767) - 16384);
         default: return sts_tb_pkg::coord_type'($urandom_range(0, 2) * 32767 -
                                                 32768 + $urandom_range(0, 1));
      endcase
   endfunction

   function automatic sts_tb_pkg::vec_type rand_vec(int mode);
      sts_tb_pkg::vec_type v;
      v.x = rand_coord(mode); v.y = rand_coord(mode); v.z = rand_coord(mode);
      return v;
   endfunction

   // Holds the triangle on the channel until the transfer happens. Valid
   // drops only for the gap between bursts.
   task automatic send_triangle(sts_tb_pkg::vec_type v0, sts_tb_pkg::vec_type v1,
                                sts_tb_pkg::vec_type v2);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 6);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.v0_x <= v0.x; req_ch.v0_y <= v0.y; req_ch.v0_z <= v0.z;
      req_ch.v1_x <= v1.x; req_ch.v1_y <= v1.y; req_ch.v1_z <= v1.z;
      req_ch.v2_x <= v2.x; req_ch.v2_y <= v2.y; req_ch.v2_z <= v2.z;
      do @(posedge clock); while (!req_ch.ready);
      board.note_triangle(v0, v1, v2);
      @(negedge clock);
   endtask

   task automatic send_directed();
      sts_tb_pkg::vec_type one_x, one_y, one_z, neg_x, mx, mn, zero;
      one_x = '{16384, 0, 0}; one_y = '{0, 16384, 0}; one_z = '{0, 0, 16384};
      neg_x = '{-16384, 0, 0};
      mx = '{32767, 32767, 32767}; mn = '{-32768, -32768, -32768};
      zero = '{0, 0, 0};
      send_triangle(one_x, one_y, one_z);
      send_triangle(one_x, neg_x, one_y);
      send_triangle(one_x, neg_x, neg_x);
      send_triangle(mx, mx, mx);
      send_triangle(mn, mn, mn);
      send_triangle(mx, mn, zero);
      send_triangle(zero, zero, zero);
      send_triangle('{1, 0, 0}, '{0, 0, -1}, '{-1, 1, 1});
      send_triangle('{32767, -32768, 1}, '{-1, -1, -1}, '{11585, 11585, 0});
      send_triangle(mn, '{-32768, 32767, 0}, '{32767, -32768, -1});
      send_triangle('{9459, 9459, 9459}, '{-9459, 9459, -9459}, one_z);
   endtask

   initial begin
      sts_tb_pkg::vec_type a, b, c;
      req_ch.valid = 1'b0;
      req_ch.v0_x = 0; req_ch.v0_y = 0; req_ch.v0_z = 0;
      req_ch.v1_x = 0; req_ch.v1_y = 0; req_ch.v1_z = 0;
      req_ch.v2_x = 0; req_ch.v2_y = 0; req_ch.v2_z = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      send_directed();
      for (int n = 0; n < 210; n++) begin
         a = rand_vec($urandom_range(0, 2));
         b = rand_vec($urandom_range(0, 2));
         c = rand_vec($urandom_range(0, 2));
         // Opposite vertices exercise the zero-length midpoint.
         if ($urandom_range(0, 9) == 0) b = '{-a.x, -a.y, -a.z};
         send_triangle(a, b, c);
      end
      req_ch.valid <= 1'b0;
      sending_done = 1;
   end

   // Result side: stalls on a rotating pattern with stall-free stretches.
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 97;
      if (reset)
         rsp_ch.ready <= 1'b0;
      else if (stall_phase < 30)
         rsp_ch.ready <= 1'b1;
      else
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_triangle('{'{rsp_ch.p0_x, rsp_ch.p0_y, rsp_ch.p0_z},
                                '{rsp_ch.p1_x, rsp_ch.p1_y, rsp_ch.p1_z},
                                '{rsp_ch.p2_x, rsp_ch.p2_y, rsp_ch.p2_z},
                                rsp_ch.last_of_run});
   end

   initial begin
      rsp_ch.ready = 1'b0;
      wait (sending_done);
      while (board.pending_tris.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0)
         $display("sphere_triangle_subdivide_tb OK");
      else
         $display("sphere_triangle_subdivide_tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("sphere_triangle_subdivide_tb NOT OK");
      $finish;
   end
endmodule
